// ===== hw/rtl/ttuip_pkg.sv =====
package ttuip_pkg;

    localparam int unsigned MAX_STRING_LEN = 255;
    localparam int unsigned POS_W = $clog2(MAX_STRING_LEN + 1);

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned RADIX_W = 6;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned OFFSET_W = 8;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;

    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] BASE_RESET = RADIX_HEX;

    // Any value at or above every legal radix marks a character that is not a digit.
    localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd63;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              final_char;
    } char_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  parsed_value;
        logic [OFFSET_W-1:0] end_offset;
        logic                range_error;
        logic                found_digits;
    } result_t;

    function automatic logic [RADIX_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = {2'b00, DIGIT_NONE};
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
            end
            else if (c >= 8'h61 && c <= 8'h7A)
            begin
                d = c - 8'h61 + 8'd10;
            end
            else if (c >= 8'h41 && c <= 8'h5A)
            begin
                d = c - 8'h41 + 8'd10;
            end
            return d[RADIX_W-1:0];
        end
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        begin
            return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        end
    endfunction

endpackage

// ===== hw/rtl/ttuip_in_stage.sv =====
module ttuip_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ttuip_pkg::char_t     in_char,
    input  logic                 out_can_load,
    output logic                 step,
    output ttuip_pkg::char_t     held_char,
    output logic                 empty
);

    logic             valid_reg;
    ttuip_pkg::char_t char_reg;

    // A final character may only move on when the result register can take its result.
    assign step = valid_reg && (!char_reg.final_char || out_can_load);
    assign in_ready = !valid_reg || step;
    assign held_char = char_reg;
    assign empty = !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= in_char;
        end
    end

endmodule

// ===== hw/rtl/ttuip_core.sv =====
module ttuip_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [ttuip_pkg::RADIX_W-1:0]           cfg_data,
    input  logic                                    step,
    input  ttuip_pkg::char_t                        cur_char,
    output logic                                    res_valid,
    output ttuip_pkg::result_t                      res
);

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_DIGITS,
        ST_OVER
    } status_t;

    localparam logic [ttuip_pkg::POS_W:0] MAX_POS =
        (ttuip_pkg::POS_W + 1)'(ttuip_pkg::MAX_STRING_LEN);

    phase_t                               phase_reg, phase_next;
    status_t                              status_reg, status_next;
    logic [ttuip_pkg::VALUE_W-1:0]        acc_reg, acc_next;
    logic                                 minus_reg, minus_next;
    logic [ttuip_pkg::RADIX_W-1:0]        radix_reg, radix_next;
    logic [ttuip_pkg::RADIX_W-1:0]        base_reg;
    logic [ttuip_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [ttuip_pkg::POS_W-1:0]          last_reg, last_next;

    logic [ttuip_pkg::POS_W:0]            pos_inc;
    logic [ttuip_pkg::POS_W-1:0]          pos_sat;
    logic [ttuip_pkg::RADIX_W-1:0]        dval;
    logic                                 first_go;
    logic                                 do_take;
    logic                                 digit_ok;
    logic [ttuip_pkg::VALUE_W+6:0]        mac;
    logic [ttuip_pkg::VALUE_W-1:0]        value;
    logic [ttuip_pkg::CHAR_W-1:0]         c;

    always_comb
    begin
        c = cur_char.char_code;
        phase_next = phase_reg;
        status_next = status_reg;
        acc_next = acc_reg;
        minus_next = minus_reg;
        radix_next = radix_reg;
        last_next = last_reg;
        first_go = 1'b0;
        do_take = 1'b0;
        res = '0;

        pos_inc = {1'b0, pos_reg} + 1'b1;
        pos_sat = (pos_inc > MAX_POS) ? MAX_POS[ttuip_pkg::POS_W-1:0]
                                      : pos_inc[ttuip_pkg::POS_W-1:0];
        dval = ttuip_pkg::digit_value(c);

        unique case (phase_reg)
            PH_SPACE:
            begin
                if (ttuip_pkg::is_space(c))
                begin
                    phase_next = PH_SPACE;
                end
                else if (c == ttuip_pkg::CH_MINUS)
                begin
                    minus_next = 1'b1;
                    phase_next = PH_SIGNED;
                end
                else if (c == ttuip_pkg::CH_PLUS)
                begin
                    phase_next = PH_SIGNED;
                end
                else
                begin
                    first_go = 1'b1;
                end
            end
            PH_SIGNED:
            begin
                first_go = 1'b1;
            end
            PH_ZERO:
            begin
                if (c == ttuip_pkg::CH_LOWER_X || c == ttuip_pkg::CH_UPPER_X)
                begin
                    radix_next = ttuip_pkg::RADIX_HEX;
                    phase_next = PH_HEXPFX;
                end
                else
                begin
                    if (radix_reg == ttuip_pkg::RADIX_AUTO)
                    begin
                        radix_next = ttuip_pkg::RADIX_OCT;
                    end
                    if (status_reg == ST_NONE)
                    begin
                        status_next = ST_DIGITS;
                    end
                    do_take = 1'b1;
                end
            end
            PH_HEXPFX:
            begin
                if (dval < ttuip_pkg::RADIX_HEX)
                begin
                    do_take = 1'b1;
                end
                else
                begin
                    if (status_reg == ST_NONE)
                    begin
                        status_next = ST_DIGITS;
                    end
                    phase_next = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                do_take = 1'b1;
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // A leading zero may still open a hex prefix, so it is held back as a pending digit.
        if (first_go)
        begin
            if ((radix_reg == ttuip_pkg::RADIX_AUTO || radix_reg == ttuip_pkg::RADIX_HEX)
                && c == ttuip_pkg::CH_ZERO)
            begin
                phase_next = PH_ZERO;
                last_next = pos_sat;
            end
            else
            begin
                if (radix_reg == ttuip_pkg::RADIX_AUTO)
                begin
                    radix_next = ttuip_pkg::RADIX_DEC;
                end
                do_take = 1'b1;
            end
        end

        digit_ok = (radix_next >= ttuip_pkg::RADIX_MIN) && (radix_next <= ttuip_pkg::RADIX_MAX)
                   && (dval < radix_next);
        mac = {7'b0, acc_reg} * {65'b0, radix_next} + {65'b0, dval};

        if (do_take)
        begin
            if (!digit_ok)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                phase_next = PH_DIGITS;
                last_next = pos_sat;
                if (status_next != ST_OVER)
                begin
                    if (|mac[ttuip_pkg::VALUE_W+6:ttuip_pkg::VALUE_W])
                    begin
                        status_next = ST_OVER;
                        acc_next = '1;
                    end
                    else
                    begin
                        status_next = ST_DIGITS;
                        acc_next = mac[ttuip_pkg::VALUE_W-1:0];
                    end
                end
            end
        end

        pos_next = pos_sat;
        res_valid = step && cur_char.final_char;

        if (cur_char.final_char)
        begin
            if ((phase_next == PH_ZERO || phase_next == PH_HEXPFX) && status_next == ST_NONE)
            begin
                status_next = ST_DIGITS;
            end
            value = (status_next == ST_NONE) ? '0 : acc_next;
            if (minus_next && status_next == ST_DIGITS)
            begin
                value = '0 - value;
            end
            res.parsed_value = value;
            res.end_offset = (status_next == ST_NONE) ? '0 : ttuip_pkg::OFFSET_W'(last_next);
            res.range_error = (status_next == ST_OVER);
            res.found_digits = (status_next != ST_NONE);

            phase_next = PH_SPACE;
            status_next = ST_NONE;
            acc_next = '0;
            minus_next = 1'b0;
            radix_next = base_reg;
            pos_next = '0;
            last_next = '0;
        end
        else
        begin
            value = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            status_reg <= ST_NONE;
            acc_reg <= '0;
            minus_reg <= 1'b0;
            radix_reg <= ttuip_pkg::BASE_RESET;
            base_reg <= ttuip_pkg::BASE_RESET;
            pos_reg <= '0;
            last_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            status_reg <= status_next;
            acc_reg <= acc_next;
            minus_reg <= minus_next;
            radix_reg <= radix_next;
            pos_reg <= pos_next;
            last_reg <= last_next;
        end
        else if (cfg_write)
        begin
            base_reg <= cfg_data;
            if (pos_reg == '0 && phase_reg == PH_SPACE)
            begin
                radix_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== hw/rtl/ttuip_out_stage.sv =====
module ttuip_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  ttuip_pkg::result_t load_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               can_load,
    output ttuip_pkg::result_t out_data
);

    logic               valid_reg;
    ttuip_pkg::result_t data_reg;

    assign can_load = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== hw/rtl/text_to_unsigned_integer_parser.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    char_code[7:0], final_char
// cfg       input      cfg_valid / cfg_ready  number_base[5:0]
// out       output     out_valid / out_ready  parsed_value[63:0], end_offset[7:0],
//                                             range_error, found_digits
//
// Each character is parsed while it sits in the input register, in the cycle after its
// transfer, so one character per cycle is sustained unless the result register stalls; the
// final character's result then goes to the result register. The single radix multiply-add on
// the 64-bit accumulator sets the cycle. Reset clears the parse state and loads base 16.
// A stalled result register holds back only the final character of the next string.
module text_to_unsigned_integer_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        final_char,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  number_base,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] parsed_value,
    output logic [7:0]  end_offset,
    output logic        range_error,
    output logic        found_digits
);

    ttuip_pkg::char_t   in_char;
    ttuip_pkg::char_t   held_char;
    ttuip_pkg::result_t res;
    ttuip_pkg::result_t out_data;
    logic               step;
    logic               empty;
    logic               res_valid;
    logic               can_load;

    assign in_char.char_code = char_code;
    assign in_char.final_char = final_char;
    assign cfg_ready = empty;

    ttuip_in_stage u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_char      (in_char),
        .out_can_load (can_load),
        .step         (step),
        .held_char    (held_char),
        .empty        (empty)
    );

    ttuip_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (number_base),
        .step      (step),
        .cur_char  (held_char),
        .res_valid (res_valid),
        .res       (res)
    );

    ttuip_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .can_load  (can_load),
        .out_data  (out_data)
    );

    assign parsed_value = out_data.parsed_value;
    assign end_offset = out_data.end_offset;
    assign range_error = out_data.range_error;
    assign found_digits = out_data.found_digits;

endmodule

// ===== hw/rtl/ttuip_checker.sv =====
module ttuip_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] parsed_value,
    input logic [7:0]  end_offset,
    input logic        range_error,
    input logic        found_digits
);

    // A result that is not taken must stay on the port with its value, end offset and range error unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(parsed_value)
                                    && $stable(end_offset) && $stable(range_error))
    else $error("Stalled result changed before its transfer.");

    // A string without digits yields zero everywhere.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found_digits |-> parsed_value == 64'd0 && end_offset == 8'd0
                                       && !range_error)
    else $error("Result without digits is not zero.");

    // Overflow saturates to all ones and implies digits were seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> parsed_value == {64{1'b1}} && found_digits)
    else $error("Overflow result is not saturated.");

    // Any converted digit leaves a nonzero end offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found_digits |-> end_offset != 8'd0)
    else $error("Digits found but end offset is zero.");

endmodule

bind text_to_unsigned_integer_parser ttuip_checker u_ttuip_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parsed_value (parsed_value),
    .end_offset   (end_offset),
    .range_error  (range_error),
    .found_digits (found_digits)
);

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] text_t[$];

    typedef enum logic [2:0] {
        PH_WHITE,
        PH_SIGN,
        PH_LEAD_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_DONE
    } scan_phase_e;

    typedef enum logic [1:0] {
        DIGITS_NONE,
        DIGITS_SEEN,
        DIGITS_OVERFLOW
    } digit_state_e;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_SO = 8'h0E;
    localparam logic [ttuip_pkg::RADIX_W-1:0] RADIX_ONE = 6'd1;
    localparam logic [ttuip_pkg::RADIX_W-1:0] RADIX_TOP = 6'd63;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int RANDOM_CHARS = 90;
    localparam int BURST_CHARS = 40;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_code = '0;
    logic        final_char = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  number_base = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] parsed_value;
    logic [7:0]  end_offset;
    logic        range_error;
    logic        found_digits;

    scan_phase_e                   scan_phase;
    digit_state_e                  digit_state;
    logic [63:0]                   accum;
    logic                          negative;
    logic [ttuip_pkg::RADIX_W-1:0] base_setting;
    logic [ttuip_pkg::RADIX_W-1:0] radix;
    int unsigned                   char_pos;
    int unsigned                   digit_end;

    ttuip_pkg::result_t expected_numbers[$];

    bit idle_on = 1'b1;
    bit rx_holding = 1'b0;
    int hold_request = 0;
    int mismatches = 0;
    int results_checked = 0;
    int chars_sent = 0;
    int strings_sent = 0;
    int base_writes = 0;
    int quiet_cycles = 0;

    text_to_unsigned_integer_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .final_char   (final_char),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .number_base  (number_base),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parsed_value (parsed_value),
        .end_offset   (end_offset),
        .range_error  (range_error),
        .found_digits (found_digits)
    );

    always #5ns clk = ~clk;

    function automatic int unsigned clamp_pos(input int unsigned p);
        return (p > ttuip_pkg::MAX_STRING_LEN) ? ttuip_pkg::MAX_STRING_LEN : p;
    endfunction

    function automatic int unsigned char_to_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c - "0";
        end
        if (c >= "a" && c <= "z")
        begin
            return c - "a" + 10;
        end
        if (c >= "A" && c <= "Z")
        begin
            return c - "A" + 10;
        end
        return 99;
    endfunction

    function automatic bit is_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void reset_string();
        scan_phase = PH_WHITE;
        accum = '0;
        negative = 1'b0;
        radix = base_setting;
        digit_state = DIGITS_NONE;
        char_pos = 0;
        digit_end = 0;
    endfunction

    // A pending zero of a possible hex prefix becomes the digit 0.
    function automatic void keep_zero();
        if (digit_state == DIGITS_NONE)
        begin
            digit_state = DIGITS_SEEN;
            accum = '0;
        end
    endfunction

    function automatic void add_digit(input logic [7:0] c, input int unsigned p);
        int unsigned d;
        logic [63:0] limit_q;
        logic [63:0] limit_r;
        d = char_to_digit(c);
        if (radix < ttuip_pkg::RADIX_MIN || radix > ttuip_pkg::RADIX_MAX || d >= radix)
        begin
            scan_phase = PH_DONE;
            return;
        end
        scan_phase = PH_DIGITS;
        digit_end = clamp_pos(p + 1);
        if (digit_state == DIGITS_OVERFLOW)
        begin
            return;
        end
        limit_q = {64{1'b1}} / 64'(radix);
        limit_r = {64{1'b1}} % 64'(radix);
        if (accum > limit_q || (accum == limit_q && 64'(d) > limit_r))
        begin
            digit_state = DIGITS_OVERFLOW;
            accum = '1;
        end
        else
        begin
            digit_state = DIGITS_SEEN;
            accum = accum * 64'(radix) + 64'(d);
        end
    endfunction

    function automatic void first_digit(input logic [7:0] c, input int unsigned p);
        if ((radix == ttuip_pkg::RADIX_AUTO || radix == ttuip_pkg::RADIX_HEX)
            && c == ttuip_pkg::CH_ZERO)
        begin
            scan_phase = PH_LEAD_ZERO;
            digit_end = clamp_pos(p + 1);
            return;
        end
        if (radix == ttuip_pkg::RADIX_AUTO)
        begin
            radix = ttuip_pkg::RADIX_DEC;
        end
        add_digit(c, p);
    endfunction

    function automatic bit parse_char(input logic [7:0] c, input logic fin,
                                      output ttuip_pkg::result_t r);
        int unsigned p;
        logic [63:0] v;
        p = char_pos;
        r = '0;
        case (scan_phase)
            PH_WHITE:
            begin
                if (!is_white(c))
                begin
                    if (c == ttuip_pkg::CH_MINUS)
                    begin
                        negative = 1'b1;
                        scan_phase = PH_SIGN;
                    end
                    else if (c == ttuip_pkg::CH_PLUS)
                    begin
                        scan_phase = PH_SIGN;
                    end
                    else
                    begin
                        first_digit(c, p);
                    end
                end
            end
            PH_SIGN:
            begin
                first_digit(c, p);
            end
            PH_LEAD_ZERO:
            begin
                if (c == ttuip_pkg::CH_LOWER_X || c == ttuip_pkg::CH_UPPER_X)
                begin
                    radix = ttuip_pkg::RADIX_HEX;
                    scan_phase = PH_PREFIX;
                end
                else
                begin
                    if (radix == ttuip_pkg::RADIX_AUTO)
                    begin
                        radix = ttuip_pkg::RADIX_OCT;
                    end
                    keep_zero();
                    add_digit(c, p);
                end
            end
            PH_PREFIX:
            begin
                if (char_to_digit(c) < ttuip_pkg::RADIX_HEX)
                begin
                    add_digit(c, p);
                end
                else
                begin
                    keep_zero();
                    scan_phase = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                add_digit(c, p);
            end
            default:
            begin
            end
        endcase
        char_pos = clamp_pos(p + 1);
        if (!fin)
        begin
            return 1'b0;
        end
        if (scan_phase == PH_LEAD_ZERO || scan_phase == PH_PREFIX)
        begin
            keep_zero();
        end
        v = (digit_state == DIGITS_NONE) ? '0 : accum;
        if (negative && digit_state == DIGITS_SEEN)
        begin
            v = 64'd0 - v;
        end
        r.parsed_value = v;
        r.end_offset = (digit_state == DIGITS_NONE) ? 8'd0 : 8'(digit_end);
        r.range_error = (digit_state == DIGITS_OVERFLOW);
        r.found_digits = (digit_state != DIGITS_NONE);
        reset_string();
        return 1'b1;
    endfunction

    function automatic text_t as_chars(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
        begin
            t.insert(t.size(), s[i]);
        end
        return t;
    endfunction

    function automatic text_t repeat_char(input logic [7:0] c, input int n);
        text_t t;
        repeat (n) t.insert(t.size(), c);
        return t;
    endfunction

    function automatic logic [7:0] digit_char(input int unsigned d);
        if (d < 10)
        begin
            return 8'(ttuip_pkg::CH_ZERO + d);
        end
        return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
    endfunction

    function automatic logic [7:0] white_char();
        int unsigned k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
    endfunction

    function automatic logic [ttuip_pkg::RADIX_W-1:0] pick_base();
        case ($urandom_range(0, 7))
            0: return ttuip_pkg::RADIX_AUTO;
            1: return ttuip_pkg::RADIX_HEX;
            2: return ttuip_pkg::RADIX_DEC;
            3: return ttuip_pkg::RADIX_OCT;
            4: return ttuip_pkg::RADIX_MIN;
            5: return ttuip_pkg::RADIX_MAX;
            6: return 6'($urandom_range(ttuip_pkg::RADIX_MIN, ttuip_pkg::RADIX_MAX));
            default: return $urandom_range(0, 1)
                            ? RADIX_ONE
                            : 6'($urandom_range(ttuip_pkg::RADIX_MAX + 1, RADIX_TOP));
        endcase
    endfunction

    function automatic text_t random_text(input logic [ttuip_pkg::RADIX_W-1:0] base);
        text_t s;
        int unsigned n;
        logic [ttuip_pkg::RADIX_W-1:0] eff;
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 12);
            repeat (n) s.insert(s.size(), 8'($urandom_range(0, 255)));
            return s;
        end
        repeat ($urandom_range(0, 2)) s.insert(s.size(), white_char());
        case ($urandom_range(0, 3))
            0: s.insert(s.size(), ttuip_pkg::CH_MINUS);
            1: s.insert(s.size(), ttuip_pkg::CH_PLUS);
            default:
            begin
            end
        endcase
        eff = base;
        if ((base == ttuip_pkg::RADIX_AUTO || base == ttuip_pkg::RADIX_HEX)
            && $urandom_range(0, 2) == 0)
        begin
            s.insert(s.size(), ttuip_pkg::CH_ZERO);
            s.insert(s.size(), $urandom_range(0, 1) ? ttuip_pkg::CH_LOWER_X
                                                    : ttuip_pkg::CH_UPPER_X);
            eff = ttuip_pkg::RADIX_HEX;
        end
        else if (base == ttuip_pkg::RADIX_AUTO)
        begin
            if ($urandom_range(0, 1))
            begin
                s.insert(s.size(), ttuip_pkg::CH_ZERO);
                eff = ttuip_pkg::RADIX_OCT;
            end
            else
            begin
                eff = ttuip_pkg::RADIX_DEC;
            end
        end
        if (eff < ttuip_pkg::RADIX_MIN || eff > ttuip_pkg::RADIX_MAX)
        begin
            eff = ttuip_pkg::RADIX_MAX;
        end
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 66) : $urandom_range(0, 8);
        repeat (n) s.insert(s.size(), digit_char($urandom_range(0, eff - 1)));
        if (s.size() > 0 && $urandom_range(0, 4) == 0)
        begin
            s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if (s.size() == 0 || $urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3)) s.insert(s.size(), 8'($urandom_range(0, 255)));
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    endtask

    // The caller stops the input stream before it lets time pass without sending.
    task automatic send_text(input text_t s);
        ttuip_pkg::result_t r;
        for (int i = 0; i < s.size(); i++)
        begin
            in_valid <= 1'b1;
            char_code <= s[i];
            final_char <= (i == s.size() - 1);
            @(posedge clk);
            while (!in_ready)
            begin
                @(posedge clk);
            end
            chars_sent++;
            if (parse_char(s[i], i == s.size() - 1, r))
            begin
                expected_numbers.insert(expected_numbers.size(), r);
                strings_sent++;
            end
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    endtask

    task automatic send_str(input string s);
        send_text(as_chars(s));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_numbers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [ttuip_pkg::RADIX_W-1:0] b);
        settle();
        cfg_valid <= 1'b1;
        number_base <= b;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        base_setting = b;
        if (char_pos == 0 && scan_phase == PH_WHITE)
        begin
            radix = b;
        end
        base_writes++;
    endtask

    task automatic test_reset_base();
        send_str("0x1F");
        send_str(" \t-12");
        send_str("+ff");
        send_str("0");
        send_str("0x");
        send_str("0xg");
        send_str("0a");
        send_str("00x1");
        send_str("FFFFFFFFFFFFFFFF");
        send_str("10000000000000000");
        send_str("-1");
        send_str("zz");
        send_str("-0x10");
        send_str("1x");
    endtask

    task automatic test_radix_settings();
        text_t t;
        write_base(ttuip_pkg::RADIX_AUTO);
        send_str("0777");
        send_str("0x1a");
        send_str("123");
        send_str("09");
        send_str("0");
        send_str("0X");
        send_str("-0");
        send_str("0xZ");
        write_base(ttuip_pkg::RADIX_DEC);
        send_str("18446744073709551615");
        send_str("18446744073709551616");
        send_str("-18446744073709551615");
        send_str("  +42abc");
        write_base(ttuip_pkg::RADIX_MIN);
        send_str("1012");
        t = repeat_char("1", 65);
        t.push_front(ttuip_pkg::CH_MINUS);
        send_text(t);
        write_base(ttuip_pkg::RADIX_OCT);
        send_str("777");
        send_str("0x7");
        send_str("1777777777777777777777");
        send_str("2000000000000000000000");
        write_base(ttuip_pkg::RADIX_MAX);
        send_str("zZ");
        send_str("-Zz!");
        write_base(RADIX_ONE);
        send_str("1");
        write_base(6'(ttuip_pkg::RADIX_MAX + 1));
        send_str("1");
        write_base(RADIX_TOP);
        send_str("a");
    endtask

    task automatic test_special_chars();
        text_t t;
        write_base(ttuip_pkg::RADIX_HEX);
        t = as_chars("12");
        t.insert(t.size(), CH_NUL);
        t.insert(t.size(), "3");
        send_text(t);
        t = '{CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, CH_SPACE, "7"};
        send_text(t);
        t = '{CH_BS, "1"};
        send_text(t);
        t = '{CH_SO, "1"};
        send_text(t);
        t = '{CH_NUL};
        send_text(t);
        t = '{8'hFF, "5"};
        send_text(t);
        send_str("-");
        send_str("+-1");
    endtask

    task automatic test_long_strings();
        text_t t;
        write_base(ttuip_pkg::RADIX_DEC);
        t = repeat_char(ttuip_pkg::CH_ZERO, 260);
        t.insert(t.size(), "7");
        send_text(t);
        t = repeat_char("9", 25);
        t.insert(t.size(), CH_SPACE);
        send_text(t);
    endtask

    task automatic test_output_stall();
        write_base(ttuip_pkg::RADIX_HEX);
        hold_request = HOLD_CYCLES;
        wait (rx_holding);
        @(posedge clk);
        send_str("12345");
        send_str("-abc");
        send_str("0x10");
        send_str("ff ff");
        send_str("  +7");
        settle();
    endtask

    task automatic test_random_strings();
        int target;
        target = chars_sent + RANDOM_CHARS;
        while (chars_sent < target)
        begin
            if (strings_sent % 8 == 0)
            begin
                write_base(pick_base());
            end
            send_text(random_text(base_setting));
        end
    endtask

    task automatic test_final_burst();
        int target;
        write_base(pick_base());
        idle_on = 1'b0;
        target = chars_sent + BURST_CHARS;
        while (chars_sent < target)
        begin
            send_text(random_text(base_setting));
        end
    endtask

    initial
    begin
        base_setting = ttuip_pkg::BASE_RESET;
        reset_string();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_base();
        test_radix_settings();
        test_special_chars();
        test_long_strings();
        test_output_stall();
        test_random_strings();
        test_final_burst();
        settle();
        $display("tb_top: %0d strings of %0d characters, %0d results compared, %0d base writes",
                 strings_sent, chars_sent, results_checked, base_writes);
        $display("tb_top: signs, prefixes, automatic and bad radix, overflow, long text, stall");
        if (mismatches == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Each output transfer is compared with the oldest predicted result.
    always @(posedge clk)
    begin
        ttuip_pkg::result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_numbers.size() == 0)
            begin
                report_mismatch("unexpected result", parsed_value, '0);
            end
            else
            begin
                e = expected_numbers.pop_front();
                results_checked++;
                if (parsed_value !== e.parsed_value)
                begin
                    report_mismatch("parsed_value", parsed_value, e.parsed_value);
                end
                if (end_offset !== e.end_offset)
                begin
                    report_mismatch("end_offset", 64'(end_offset), 64'(e.end_offset));
                end
                if (range_error !== e.range_error)
                begin
                    report_mismatch("range_error", 64'(range_error), 64'(e.range_error));
                end
                if (found_digits !== e.found_digits)
                begin
                    report_mismatch("found_digits", 64'(found_digits), 64'(e.found_digits));
                end
            end
        end
    end

    initial
    begin
        int n;
        @(posedge clk);
        forever
        begin
            if (hold_request != 0)
            begin
                n = hold_request;
                hold_request = 0;
                rx_holding = 1'b1;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                rx_holding = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_numbers.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

endmodule
